// ----- rtl/core/qslp_pkg.sv -----
// qslp_pkg: shared types and constants for the quaternion slerp unit.
// Transfer structs, CORDIC width and arctangent table. No dependencies.
`timescale 1ns / 1ps

package qslp_pkg;

  // CORDIC datapath width (x, y and angle), Q30 values with headroom
  localparam int CW = 34;

  localparam logic [16:0] T_ONE   = 17'h10000;
  localparam logic [33:0] Q30_ONE = 34'h40000000;

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] a_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] b_w;
    logic [16:0]        frac_t;
  } in_t;

  typedef struct packed {
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic signed [15:0] r_w;
    logic               used_linear;
  } out_t;

  // atan(2^-i) in Q30
  function automatic logic [31:0] atan_val(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      24: v = 32'd63;
      25: v = 32'd31;
      26: v = 32'd15;
      27: v = 32'd7;
      28: v = 32'd3;
      29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/qslp_isqrt.sv -----
// qslp_isqrt: pipelined floor square root, one result bit per stage.
// Carries a sideband word alongside. Depends on nothing.
`timescale 1ns / 1ps

module qslp_isqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     in_val,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int STG = IN_W / 2;

  logic              vld  [STG];
  logic [IN_W-1:0]   rem  [STG];
  logic [IN_W-1:0]   root [STG];
  logic [SIDE_W-1:0] side [STG];

  for (genvar k = 0; k < STG; k++) begin : g_stg
    localparam logic [IN_W:0] BIT = (IN_W+1)'(1) << (IN_W - 2 - 2*k);
    logic              vld_in;
    logic [IN_W-1:0]   rem_in;
    logic [IN_W-1:0]   root_in;
    logic [SIDE_W-1:0] side_in;
    logic [IN_W:0]     trial;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_val;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign vld_in  = vld[k-1];
      assign rem_in  = rem[k-1];
      assign root_in = root[k-1];
      assign side_in = side[k-1];
    end

    assign trial = {1'b0, root_in} + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      side[k] <= side_in;
      if ({1'b0, rem_in} >= trial) begin
        rem[k]  <= rem_in - trial[IN_W-1:0];
        root[k] <= (root_in >> 1) + BIT[IN_W-1:0];
      end else begin
        rem[k]  <= rem_in;
        root[k] <= root_in >> 1;
      end
    end
  end

  assign out_valid = vld[STG-1];
  assign out_root  = root[STG-1][STG-1:0];
  assign out_side  = side[STG-1];

endmodule

// ----- rtl/core/qslp_cordic.sv -----
// qslp_cordic: pipelined CORDIC, vectoring or rotation, one iteration per stage.
// Several lanes share the valid and sideband. Depends on qslp_pkg.
`timescale 1ns / 1ps

module qslp_cordic #(
  parameter int VEC        = 0,
  parameter int ITERATIONS = 16,
  parameter int LANES      = 1,
  parameter int SIDE_W     = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic [LANES-1:0][qslp_pkg::CW-1:0]   in_x,
  input  logic [LANES-1:0][qslp_pkg::CW-1:0]   in_y,
  input  logic [LANES-1:0][qslp_pkg::CW-1:0]   in_z,
  input  logic [SIDE_W-1:0]                    in_side,
  output logic                                 out_valid,
  output logic [LANES-1:0][qslp_pkg::CW-1:0]   out_y,
  output logic [LANES-1:0][qslp_pkg::CW-1:0]   out_z,
  output logic [SIDE_W-1:0]                    out_side
);

  localparam int CW = qslp_pkg::CW;

  logic                       vld [ITERATIONS];
  logic [LANES-1:0][CW-1:0]   xs  [ITERATIONS];
  logic [LANES-1:0][CW-1:0]   ys  [ITERATIONS];
  logic [LANES-1:0][CW-1:0]   zs  [ITERATIONS];
  logic [SIDE_W-1:0]          sd  [ITERATIONS];

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_it
    localparam logic [CW-1:0] ATN = CW'(qslp_pkg::atan_val(i));
    logic                     vld_in;
    logic [LANES-1:0][CW-1:0] x_in, y_in, z_in;
    logic [LANES-1:0][CW-1:0] x_nx, y_nx, z_nx;
    logic [SIDE_W-1:0]        sd_in;

    if (i == 0) begin : g_first
      assign vld_in = in_valid;
      assign x_in   = in_x;
      assign y_in   = in_y;
      assign z_in   = in_z;
      assign sd_in  = in_side;
    end else begin : g_rest
      assign vld_in = vld[i-1];
      assign x_in   = xs[i-1];
      assign y_in   = ys[i-1];
      assign z_in   = zs[i-1];
      assign sd_in  = sd[i-1];
    end

    always_comb begin
      logic signed [CW-1:0] x, y, z, xsh, ysh;
      logic                 sub;
      for (int l = 0; l < LANES; l++) begin
        x   = signed'(x_in[l]);
        y   = signed'(y_in[l]);
        z   = signed'(z_in[l]);
        xsh = x >>> i;
        ysh = y >>> i;
        // vectoring drives y toward zero, rotation drives z toward zero
        sub = (VEC != 0) ? (y > 0) : (z < 0);
        if (sub) begin
          x_nx[l] = x + ysh;
          y_nx[l] = y - xsh;
          z_nx[l] = z + signed'(ATN);
        end else begin
          x_nx[l] = x - ysh;
          y_nx[l] = y + xsh;
          z_nx[l] = z - signed'(ATN);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      xs[i] <= x_nx;
      ys[i] <= y_nx;
      zs[i] <= z_nx;
      sd[i] <= sd_in;
    end
  end

  assign out_valid = vld[ITERATIONS-1];
  assign out_y     = ys[ITERATIONS-1];
  assign out_z     = zs[ITERATIONS-1];
  assign out_side  = sd[ITERATIONS-1];

endmodule

// ----- rtl/core/qslp_div4.sv -----
// qslp_div4: pipelined restoring divider, four numerators over one divisor.
// One quotient bit per stage. Depends on nothing.
`timescale 1ns / 1ps

module qslp_div4 #(
  parameter int NUM_W  = 46,
  parameter int DEN_W  = 32,
  parameter int QB     = 15,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [3:0][NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0]      in_den,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [3:0][QB-1:0]    out_q,
  output logic [SIDE_W-1:0]     out_side
);

  logic                  vld [QB];
  logic [3:0][NUM_W-1:0] rem [QB];
  logic [3:0][QB-1:0]    quo [QB];
  logic [DEN_W-1:0]      den [QB];
  logic [SIDE_W-1:0]     sd  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stg
    localparam int SH = QB - 1 - k;
    logic                  vld_in;
    logic [3:0][NUM_W-1:0] rem_in, rem_nx;
    logic [3:0][QB-1:0]    quo_in, quo_nx;
    logic [DEN_W-1:0]      den_in;
    logic [SIDE_W-1:0]     sd_in;
    logic [NUM_W:0]        dsh;

    if (k == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = in_num;
      assign quo_in = '0;
      assign den_in = in_den;
      assign sd_in  = in_side;
    end else begin : g_rest
      assign vld_in = vld[k-1];
      assign rem_in = rem[k-1];
      assign quo_in = quo[k-1];
      assign den_in = den[k-1];
      assign sd_in  = sd[k-1];
    end

    assign dsh = (NUM_W+1)'(den_in) << SH;

    always_comb begin
      logic fits;
      for (int l = 0; l < 4; l++) begin
        fits = {1'b0, rem_in[l]} >= dsh;
        rem_nx[l] = fits ? (rem_in[l] - dsh[NUM_W-1:0]) : rem_in[l];
        quo_nx[l] = {quo_in[l][QB-2:0], fits};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= rem_nx;
      quo[k] <= quo_nx;
      den[k] <= den_in;
      sd[k]  <= sd_in;
    end
  end

  assign out_valid = vld[QB-1];
  assign out_q     = quo[QB-1];
  assign out_side  = sd[QB-1];

endmodule

// ----- rtl/core/quat_slerp_unit.sv -----
// quat_slerp_unit: fully pipelined quaternion slerp with nlerp fallback.
// Accepts one transfer per cycle.
// Depth is set by the two floor square roots, the two CORDIC chains and the divider.
// busy stays low: the pipeline never stalls, results leave on done for one cycle.
// Synchronous reset clears only the valid bits; payload registers are not reset.
`timescale 1ns / 1ps

module quat_slerp_unit #(
  parameter int FRAC_BITS  = 14,
  parameter int ITERATIONS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  qslp_pkg::in_t   in_item,
  output logic            done,
  output qslp_pkg::out_t  result
);

  localparam int CW = qslp_pkg::CW;

  // nlerp threshold: 1 - 1/2000 in Q(2*FRAC_BITS)
  localparam logic [63:0] ONE2 = 64'(1) << (2 * FRAC_BITS);
  localparam logic [63:0] THR  = ONE2 - ONE2 / 64'd2000;
  // rescale of the dot product to Q30
  localparam int SHR = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
  localparam int SHL = (2 * FRAC_BITS >= 30) ? 0 : 30 - 2 * FRAC_BITS;
  localparam int QB    = FRAC_BITS + 1;
  localparam int NUM_W = 32 + FRAC_BITS;
  // identity w, saturated when 1.0 does not fit the output
  localparam logic [15:0] ID_W = (FRAC_BITS >= 15) ? 16'h7fff : 16'(1 << FRAC_BITS);

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][16:0] bn;
    logic [16:0]      t;
    logic             lin;
    logic [29:0]      c;
    logic [3:0][35:0] vlin;
  } fr_side_t;

  typedef struct packed {
    logic [3:0][30:0] wmag;
    logic [3:0]       neg;
    logic             zero;
    logic             lin;
  } nm_side_t;

  function automatic logic [15:0] sat16(input logic signed [39:0] v);
    logic [15:0] r;
    if (v > 40'sd32767) begin
      r = 16'h7fff;
    end else if (v < -40'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign busy = 1'b0;

  // ---------------------------------------------------------------
  // Stage 1: capture, clamp t, component products a*b
  // ---------------------------------------------------------------
  logic [3:0][15:0] in_a, in_b;
  assign in_a = {in_item.a_w, in_item.a_z, in_item.a_y, in_item.a_x};
  assign in_b = {in_item.b_w, in_item.b_z, in_item.b_y, in_item.b_x};

  logic             s1_vld;
  logic [3:0][15:0] s1_a, s1_b;
  logic [3:0][31:0] s1_p;
  logic [16:0]      s1_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s1_a[i] <= in_a[i];
      s1_b[i] <= in_b[i];
      s1_p[i] <= 32'(signed'(in_a[i]) * signed'(in_b[i]));
    end
    s1_t <= (in_item.frac_t > qslp_pkg::T_ONE) ? qslp_pkg::T_ONE : in_item.frac_t;
  end

  // ---------------------------------------------------------------
  // Stage 2: dot sum, shortest-path flip, nlerp decision, Q30 cosine
  // ---------------------------------------------------------------
  logic signed [33:0] dot;
  logic               dneg;
  logic [32:0]        dabs;
  logic [63:0]        c64;
  logic [3:0][16:0]   bn_c;

  always_comb begin
    logic signed [16:0] bx;
    dot = '0;
    for (int i = 0; i < 4; i++) begin
      dot = dot + 34'(signed'(s1_p[i]));
    end
    dneg = dot[33];
    dabs = dneg ? 33'(-dot) : dot[32:0];
    c64  = ({31'b0, dabs} >> SHR) << SHL;
    for (int i = 0; i < 4; i++) begin
      bx      = 17'(signed'(s1_b[i]));
      bn_c[i] = dneg ? -bx : bx;
    end
  end

  logic             s2_vld;
  logic [3:0][15:0] s2_a;
  logic [3:0][16:0] s2_bn;
  logic [16:0]      s2_t;
  logic             s2_lin;
  logic [29:0]      s2_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_a   <= s1_a;
    s2_bn  <= bn_c;
    s2_t   <= s1_t;
    s2_lin <= {31'b0, dabs} > THR;
    s2_c   <= c64[29:0];
  end

  // ---------------------------------------------------------------
  // Stage 3: c*c for the sine, t*(b-a) for the linear path
  // ---------------------------------------------------------------
  logic             s3_vld;
  logic [59:0]      s3_cc;
  logic [3:0][35:0] s3_tp;
  logic [3:0][15:0] s3_a;
  logic [3:0][16:0] s3_bn;
  logic [16:0]      s3_t;
  logic             s3_lin;
  logic [29:0]      s3_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_cc <= {30'b0, s2_c} * {30'b0, s2_c};
    for (int i = 0; i < 4; i++) begin
      s3_tp[i] <= 36'(signed'({1'b0, s2_t}) *
                      (18'(signed'(s2_bn[i])) - 18'(signed'(s2_a[i]))));
    end
    s3_a   <= s2_a;
    s3_bn  <= s2_bn;
    s3_t   <= s2_t;
    s3_lin <= s2_lin;
    s3_c   <= s2_c;
  end

  // ---------------------------------------------------------------
  // sin(omega) = sqrt(1 - c^2), linear sum rides along as sideband
  // ---------------------------------------------------------------
  logic [61:0] sq1_in;
  fr_side_t    fr_in;

  always_comb begin
    sq1_in     = (62'(1) << 60) - {2'b0, s3_cc};
    fr_in.a    = s3_a;
    fr_in.bn   = s3_bn;
    fr_in.t    = s3_t;
    fr_in.lin  = s3_lin;
    fr_in.c    = s3_c;
    for (int i = 0; i < 4; i++) begin
      fr_in.vlin[i] = (36'(signed'(s3_a[i])) <<< 16) + signed'(s3_tp[i]);
    end
  end

  logic        sq1_vld;
  logic [30:0] sq1_root;
  fr_side_t    sq1_side;

  qslp_isqrt #(
    .IN_W   (62),
    .SIDE_W ($bits(fr_side_t))
  ) u_sin_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_vld),
    .in_val    (sq1_in),
    .in_side   (fr_in),
    .out_valid (sq1_vld),
    .out_root  (sq1_root),
    .out_side  (sq1_side)
  );

  // omega = atan2(s, c)
  logic                 cv_vld;
  logic [0:0][CW-1:0]   cv_z;
  fr_side_t             cv_side;

  qslp_cordic #(
    .VEC        (1),
    .ITERATIONS (ITERATIONS),
    .LANES      (1),
    .SIDE_W     ($bits(fr_side_t))
  ) u_acos (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq1_vld),
    .in_x      (CW'(sq1_side.c)),
    .in_y      (CW'(sq1_root)),
    .in_z      ('0),
    .in_side   (sq1_side),
    .out_valid (cv_vld),
    .out_y     (),
    .out_z     (cv_z),
    .out_side  (cv_side)
  );

  // ---------------------------------------------------------------
  // Stage 5: angles (1-t)*omega and t*omega
  // ---------------------------------------------------------------
  logic        s5_vld;
  logic [51:0] s5_m0, s5_m1;
  fr_side_t    s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= cv_vld;
    end
  end

  always_ff @(posedge clk) begin
    s5_m0   <= 52'(signed'({1'b0, qslp_pkg::T_ONE - cv_side.t}) * signed'(cv_z[0]));
    s5_m1   <= 52'(signed'({1'b0, cv_side.t}) * signed'(cv_z[0]));
    s5_side <= cv_side;
  end

  // two sines in parallel lanes: lane 0 weights a, lane 1 weights b
  logic               cr_vld;
  logic [1:0][CW-1:0] cr_y;
  fr_side_t           cr_side;

  qslp_cordic #(
    .VEC        (0),
    .ITERATIONS (ITERATIONS),
    .LANES      (2),
    .SIDE_W     ($bits(fr_side_t))
  ) u_sin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_vld),
    .in_x      ({qslp_pkg::Q30_ONE, qslp_pkg::Q30_ONE}),
    .in_y      ('0),
    .in_z      ({s5_m1[CW+15:16], s5_m0[CW+15:16]}),
    .in_side   (s5_side),
    .out_valid (cr_vld),
    .out_y     (cr_y),
    .out_z     (),
    .out_side  (cr_side)
  );

  // ---------------------------------------------------------------
  // Stage 7: weighted products
  // ---------------------------------------------------------------
  logic             s7_vld;
  logic [3:0][49:0] s7_pa;
  logic [3:0][50:0] s7_pb;
  logic             s7_lin;
  logic [3:0][35:0] s7_vlin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else begin
      s7_vld <= cr_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s7_pa[i] <= 50'(signed'(cr_side.a[i]) * signed'(cr_y[0]));
      s7_pb[i] <= 51'(signed'(cr_side.bn[i]) * signed'(cr_y[1]));
    end
    s7_lin  <= cr_side.lin;
    s7_vlin <= cr_side.vlin;
  end

  // ---------------------------------------------------------------
  // Stage 8: pick the vector to normalize
  // ---------------------------------------------------------------
  logic             s8_vld;
  logic [3:0][51:0] s8_v;
  logic             s8_lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else begin
      s8_vld <= s7_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (s7_lin) begin
        s8_v[i] <= 52'(signed'(s7_vlin[i]));
      end else begin
        s8_v[i] <= 52'(signed'(s7_pa[i])) + 52'(signed'(s7_pb[i]));
      end
    end
    s8_lin <= s7_lin;
  end

  // ---------------------------------------------------------------
  // Stages 9-11: magnitudes, largest magnitude, leading one
  // ---------------------------------------------------------------
  logic             s9_vld;
  logic [3:0][50:0] s9_mag;
  logic [3:0][51:0] s9_v;
  logic             s9_lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_vld <= 1'b0;
    end else begin
      s9_vld <= s8_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s9_mag[i] <= s8_v[i][51] ? 51'(-signed'(s8_v[i])) : s8_v[i][50:0];
    end
    s9_v   <= s8_v;
    s9_lin <= s8_lin;
  end

  logic [50:0] max01, max23;
  assign max01 = (s9_mag[0] > s9_mag[1]) ? s9_mag[0] : s9_mag[1];
  assign max23 = (s9_mag[2] > s9_mag[3]) ? s9_mag[2] : s9_mag[3];

  logic             s10_vld;
  logic [50:0]      s10_m;
  logic [3:0][51:0] s10_v;
  logic             s10_lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_vld <= 1'b0;
    end else begin
      s10_vld <= s9_vld;
    end
  end

  always_ff @(posedge clk) begin
    s10_m   <= (max01 > max23) ? max01 : max23;
    s10_v   <= s9_v;
    s10_lin <= s9_lin;
  end

  logic [5:0] lead;
  always_comb begin
    lead = '0;
    for (int i = 0; i < 51; i++) begin
      if (s10_m[i]) begin
        lead = 6'(i);
      end
    end
  end

  logic             s11_vld;
  logic [5:0]       s11_p;
  logic             s11_zero;
  logic [3:0][51:0] s11_v;
  logic             s11_lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_vld <= 1'b0;
    end else begin
      s11_vld <= s10_vld;
    end
  end

  always_ff @(posedge clk) begin
    s11_p    <= lead;
    s11_zero <= (s10_m == '0);
    s11_v    <= s10_v;
    s11_lin  <= s10_lin;
  end

  // ---------------------------------------------------------------
  // Stage 12: bring the largest magnitude to bit 29
  // ---------------------------------------------------------------
  logic [3:0][30:0] w_c;
  always_comb begin
    logic signed [51:0] sft;
    for (int i = 0; i < 4; i++) begin
      if (s11_p >= 6'd30) begin
        sft = signed'(s11_v[i]) >>> (s11_p - 6'd29);
      end else begin
        sft = signed'(s11_v[i]) <<< (6'd29 - s11_p);
      end
      w_c[i] = sft[30:0];
    end
  end

  logic             s12_vld;
  logic [3:0][30:0] s12_w;
  logic             s12_zero;
  logic             s12_lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_vld <= 1'b0;
    end else begin
      s12_vld <= s11_vld;
    end
  end

  always_ff @(posedge clk) begin
    s12_w    <= w_c;
    s12_zero <= s11_zero;
    s12_lin  <= s11_lin;
  end

  // ---------------------------------------------------------------
  // Stages 13-14: squares and squared length
  // ---------------------------------------------------------------
  logic             s13_vld;
  logic [3:0][61:0] s13_sq;
  nm_side_t         s13_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s13_vld <= 1'b0;
    end else begin
      s13_vld <= s12_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s13_sq[i]        <= 62'(signed'(s12_w[i]) * signed'(s12_w[i]));
      s13_side.wmag[i] <= s12_w[i][30] ? 31'(-signed'(s12_w[i])) : s12_w[i];
      s13_side.neg[i]  <= s12_w[i][30];
    end
    s13_side.zero <= s12_zero;
    s13_side.lin  <= s12_lin;
  end

  logic        s14_vld;
  logic [63:0] s14_len2;
  nm_side_t    s14_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s14_vld <= 1'b0;
    end else begin
      s14_vld <= s13_vld;
    end
  end

  always_ff @(posedge clk) begin
    s14_len2 <= {2'b0, s13_sq[0]} + {2'b0, s13_sq[1]} +
                {2'b0, s13_sq[2]} + {2'b0, s13_sq[3]};
    s14_side <= s13_side;
  end

  logic        sq2_vld;
  logic [31:0] sq2_len;
  nm_side_t    sq2_side;

  qslp_isqrt #(
    .IN_W   (64),
    .SIDE_W ($bits(nm_side_t))
  ) u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s14_vld),
    .in_val    (s14_len2),
    .in_side   (s14_side),
    .out_valid (sq2_vld),
    .out_root  (sq2_len),
    .out_side  (sq2_side)
  );

  // ---------------------------------------------------------------
  // Divide: round-half-up(|w| * 2^FRAC_BITS / len)
  // ---------------------------------------------------------------
  logic [3:0][NUM_W-1:0] div_num;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      div_num[i] = (NUM_W'(sq2_side.wmag[i]) << FRAC_BITS) + NUM_W'(sq2_len >> 1);
    end
  end

  logic               dv_vld;
  logic [3:0][QB-1:0] dv_q;
  nm_side_t           dv_side;

  qslp_div4 #(
    .NUM_W  (NUM_W),
    .DEN_W  (32),
    .QB     (QB),
    .SIDE_W ($bits(nm_side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq2_vld),
    .in_num    (div_num),
    .in_den    (sq2_len),
    .in_side   (sq2_side),
    .out_valid (dv_vld),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  // ---------------------------------------------------------------
  // Output: sign, saturate, zero-length handling
  // ---------------------------------------------------------------
  logic [3:0][15:0] r_c;
  always_comb begin
    logic signed [QB:0] sv;
    for (int i = 0; i < 4; i++) begin
      sv = dv_side.neg[i] ? -signed'({1'b0, dv_q[i]}) : signed'({1'b0, dv_q[i]});
      r_c[i] = sat16(40'(sv));
    end
    if (dv_side.zero) begin
      // zero-length nlerp stays zero, zero-length slerp becomes identity
      r_c[0] = '0;
      r_c[1] = '0;
      r_c[2] = '0;
      r_c[3] = dv_side.lin ? 16'h0000 : ID_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    result.r_x         <= r_c[0];
    result.r_y         <= r_c[1];
    result.r_z         <= r_c[2];
    result.r_w         <= r_c[3];
    result.used_linear <= dv_side.lin;
  end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for quat_slerp_unit.
// Drives random and directed slerp requests, predicts each result in a scoreboard class.
// Depends on qslp_pkg and the quat_slerp_unit RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int FB      = 14;
  localparam int ITERS   = 16;
  localparam int LATENCY = 77 + 2 * ITERS + FB;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  qslp_pkg::in_t  in_item = '0;
  qslp_pkg::out_t result;

  int   fail_count = 0;
  longint cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quat_slerp_unit #(.FRAC_BITS(FB), .ITERATIONS(ITERS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_item(in_item), .done(done), .result(result)
  );

  // Scoreboard: predicts the interpolated quaternion and holds pending ones.
  class slerp_scoreboard;
    qslp_pkg::out_t pending[$];
    longint atan_q30[32];

    function new();
      atan_q30 = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                   16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                   131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                   127, 63, 31, 15, 7, 3, 1, 0, 0};
    endfunction

    function longint shr(longint v, int n);
      return v >>> n;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= r + bitv) begin
          v -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
      return r;
    endfunction

    function longint vec_angle(longint y, longint x);
      longint z, nx, ny;
      z = 0;
      for (int i = 0; i < ITERS && i < 32; i++) begin
        if (y > 0) begin
          nx = x + shr(y, i); ny = y - shr(x, i); z += atan_q30[i];
        end else begin
          nx = x - shr(y, i); ny = y + shr(x, i); z -= atan_q30[i];
        end
        x = nx; y = ny;
      end
      return z;
    endfunction

    function longint gained_sin(longint z);
      longint x, y, nx, ny;
      x = 64'd1 << 30;
      y = 0;
      for (int i = 0; i < ITERS && i < 32; i++) begin
        if (z >= 0) begin
          nx = x - shr(y, i); ny = y + shr(x, i); z -= atan_q30[i];
        end else begin
          nx = x + shr(y, i); ny = y - shr(x, i); z += atan_q30[i];
        end
        x = nx; y = ny;
      end
      return y;
    endfunction

    function logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
    endfunction

    // Unit-length scaling; returns 0 for a zero vector.
    function bit unitize(longint v[4], output logic signed [15:0] r[4]);
      longint unsigned m, mag[4], len2, len, q;
      longint w[4];
      int sh, ls;
      m = 0; len2 = 0; sh = 0; ls = 0;
      for (int i = 0; i < 4; i++) begin
        mag[i] = v[i] < 0 ? -v[i] : v[i];
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) return 1'b0;
      while ((m >> sh) >= (64'd1 << 30)) sh++;
      if (sh == 0)
        while ((m << ls) < (64'd1 << 29)) ls++;
      for (int i = 0; i < 4; i++) begin
        w[i] = sh != 0 ? shr(v[i], sh) : v[i] * (longint'(1) << ls);
        mag[i] = w[i] < 0 ? -w[i] : w[i];
        len2 += mag[i] * mag[i];
      end
      len = floor_sqrt(len2);
      for (int i = 0; i < 4; i++) begin
        q = ((mag[i] << FB) + len / 2) / len;
        r[i] = clip16(w[i] < 0 ? -longint'(q) : longint'(q));
      end
      return 1'b1;
    endfunction

    function void note_request(qslp_pkg::in_t it);
      longint a[4], b[4], v[4], dot, one2, thr, t, c, s, omega, w0, w1;
      logic signed [15:0] r[4];
      qslp_pkg::out_t e;
      a = '{it.a_x, it.a_y, it.a_z, it.a_w};
      b = '{it.b_x, it.b_y, it.b_z, it.b_w};
      dot = 0;
      for (int i = 0; i < 4; i++) dot += a[i] * b[i];
      t = it.frac_t;
      if (t > 65536) t = 65536;
      // shortest path: flip b on a negative dot, zero dot left as is
      if (dot < 0) begin
        dot = -dot;
        for (int i = 0; i < 4; i++) b[i] = -b[i];
      end
      one2 = longint'(1) << (2 * FB);
      thr = one2 - one2 / 2000;
      e = '0;
      if (dot > thr) begin
        e.used_linear = 1'b1;
        for (int i = 0; i < 4; i++) v[i] = a[i] * 65536 + t * (b[i] - a[i]);
        if (!unitize(v, r)) r = '{0, 0, 0, 0};
      end else begin
        c = (2 * FB >= 30) ? dot >>> (2 * FB - 30) : dot * (longint'(1) << (30 - 2 * FB));
        s = floor_sqrt((longint'(1) << 60) - c * c);
        omega = vec_angle(s, c);
        w0 = gained_sin(shr((65536 - t) * omega, 16));
        w1 = gained_sin(shr(t * omega, 16));
        for (int i = 0; i < 4; i++) v[i] = a[i] * w0 + b[i] * w1;
        // degenerate slerp sum falls back to the identity
        if (!unitize(v, r)) r = '{0, 0, 0, clip16(longint'(1) << FB)};
      end
      e.r_x = r[0]; e.r_y = r[1]; e.r_z = r[2]; e.r_w = r[3];
      pending.push_back(e);
    endfunction

    function int check_result(qslp_pkg::out_t got);
      qslp_pkg::out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        return 1;
      end
      e = pending.pop_front();
      if (got !== e) begin
        $display({"%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d lin=%0b",
                  " actual x=%0d y=%0d z=%0d w=%0d lin=%0b"},
                 $time, e.r_x, e.r_y, e.r_z, e.r_w, e.used_linear,
                 got.r_x, got.r_y, got.r_z, got.r_w, got.used_linear);
        return 1;
      end
      return 0;
    endfunction
  endclass

  slerp_scoreboard sb = new();

  // Results are sampled at the edge that ends the strobe cycle.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) fail_count <= fail_count + sb.check_result(result);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic signed [15:0] rnd_comp();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd16384;
      3: return -16'sd16384;
      4: return 16'sd0;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [16:0] rnd_t();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'h10000;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Mostly components in [-8192, 8192]; b often a small nudge of a (sometimes negated) for the linear path.
  function automatic qslp_pkg::in_t rnd_item();
    qslp_pkg::in_t it;
    int k;
    k = $urandom_range(0, 9);
    it.a_x = rnd_comp(); it.a_y = rnd_comp(); it.a_z = rnd_comp(); it.a_w = rnd_comp();
    it.b_x = rnd_comp(); it.b_y = rnd_comp(); it.b_z = rnd_comp(); it.b_w = rnd_comp();
    if (k < 6) begin
      it.a_x = 16'($signed($urandom_range(0, 16384)) - 8192);
      it.a_y = 16'($signed($urandom_range(0, 16384)) - 8192);
      it.a_z = 16'($signed($urandom_range(0, 16384)) - 8192);
      it.a_w = 16'($signed($urandom_range(0, 16384)) - 8192);
      if (k < 3) begin
        it.b_x = 16'(it.a_x + $signed($urandom_range(0, 40)) - 20);
        it.b_y = 16'(it.a_y + $signed($urandom_range(0, 40)) - 20);
        it.b_z = 16'(it.a_z + $signed($urandom_range(0, 40)) - 20);
        it.b_w = 16'(it.a_w + $signed($urandom_range(0, 40)) - 20);
        if (k == 0) begin
          it.b_x = -it.b_x; it.b_y = -it.b_y; it.b_z = -it.b_z; it.b_w = -it.b_w;
        end
      end else begin
        it.b_x = 16'($signed($urandom_range(0, 16384)) - 8192);
        it.b_y = 16'($signed($urandom_range(0, 16384)) - 8192);
        it.b_z = 16'($signed($urandom_range(0, 16384)) - 8192);
        it.b_w = 16'($signed($urandom_range(0, 16384)) - 8192);
      end
    end
    it.frac_t = rnd_t();
    return it;
  endfunction

  function automatic qslp_pkg::in_t mk(int ax, int ay, int az, int aw,
                                       int bx, int by, int bz, int bw, int t);
    qslp_pkg::in_t it;
    it.a_x = 16'(ax); it.a_y = 16'(ay); it.a_z = 16'(az); it.a_w = 16'(aw);
    it.b_x = 16'(bx); it.b_y = 16'(by); it.b_z = 16'(bz); it.b_w = 16'(bw);
    it.frac_t = 17'(t);
    return it;
  endfunction

  // One transfer: hold start until accepted, then optionally drop it.
  task automatic send_item(qslp_pkg::in_t it, bit keep);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_request(it);
    if (!keep) start <= 1'b0;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  qslp_pkg::in_t directed[$];
  int  burst;

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, opposite, orthogonal, colinear, zero, extremes, t above one
    directed.push_back(mk(0, 0, 0, 16384, 0, 0, 0, 16384, 32768));
    directed.push_back(mk(0, 0, 0, 16384, 0, 0, 0, -16384, 32768));
    directed.push_back(mk(16384, 0, 0, 0, 0, 16384, 0, 0, 0));
    directed.push_back(mk(16384, 0, 0, 0, 0, 16384, 0, 0, 65536));
    directed.push_back(mk(16384, 0, 0, 0, 0, 16384, 0, 0, 131071));
    directed.push_back(mk(16384, 0, 0, 0, 0, 16384, 0, 0, 21845));
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 30000));
    directed.push_back(mk(16384, 0, 0, 0, -16384, 0, 0, 0, 32768));
    directed.push_back(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 32768));
    directed.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 65536));
    directed.push_back(mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 0));
    directed.push_back(mk(-32768, 0, 0, 0, 0, 0, 0, -32768, 40000));
    directed.push_back(mk(0, 0, 0, 0, 16384, 0, 0, 0, 65536));
    directed.push_back(mk(16384, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(1, 0, 0, 0, 0, 1, 0, 0, 32768));
    directed.push_back(mk(16384, 0, 0, 0, 16380, 200, 0, 0, 1000));
    directed.push_back(mk(11585, 11585, 0, 0, 16384, 0, 0, 0, 50000));
    directed.push_back(mk(8192, 8192, 8192, 8192, -8192, 8192, -8192, 8192, 12345));
    directed.push_back(mk(1, -1, 1, -1, -1, 1, -1, 1, 65535));
    directed.push_back(mk(0, 0, 0, 16384, 0, 0, 0, 16384, 65537));
    foreach (directed[i]) send_item(directed[i], i != directed.size() - 1);
    drain();

    for (int n = 0; n < 650; n++) begin
      // pause until the pipeline has emptied once mid-run; start already dropped
      if (n == 300) begin
        drain();
      end
      burst = $urandom_range(0, 3);
      send_item(rnd_item(), burst != 0 && n != 649 && n != 299);
      if (burst == 0) idle_gap();
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk);

    if (fail_count == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
